FILE: rtl/dfm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dfm_pkg
// Shared types, codes and the CRC-16/ARC byte step for the frame deframer.
// ---------------------------------------------------------------------------
package dfm_pkg;

   localparam logic [7:0]  START_BYTE     = 8'h55;
   localparam logic [7:0]  END_BYTE       = 8'hAA;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [15:0] FRAME_OVERHEAD = 16'd9;
   localparam logic [15:0] CAPACITY_RESET = 16'd256;

   localparam int DFM_QUEUE_DEPTH = 4;

   // byte classes handed from the front end to the back end
   localparam logic [1:0] CLS_DATA      = 2'd0;
   localparam logic [1:0] CLS_START     = 2'd1;
   localparam logic [1:0] CLS_BAD_START = 2'd2;

   // result kinds
   localparam logic KIND_CONTENT   = 1'b0;
   localparam logic KIND_FRAME_END = 1'b1;

   // frame end status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_START = 3'd1;
   localparam logic [2:0] ST_TOO_LONG  = 3'd2;
   localparam logic [2:0] ST_BAD_END   = 3'd3;
   localparam logic [2:0] ST_CRC_ERR   = 3'd4;

   typedef struct packed {
      logic [1:0] cls;
      logic [7:0] data;
   } dfm_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } dfm_queue_status_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  content;
      logic [7:0]  frame_type;
      logic [15:0] register_number;
      logic [15:0] content_length;
      logic [2:0]  status;
   } dfm_result_type;

   // reflected CRC-16 step over one byte, LSB first
   function automatic logic [15:0] crc16_arc_byte(input logic [15:0] crc,
                                                  input logic [7:0]  b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/dfm_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dfm_front
// Accepts received bytes and tags each as frame start, bad start or data.
// ---------------------------------------------------------------------------
module dfm_front
   import dfm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [7:0]           req_tdata,   // data_byte[7:0]
   input  logic                 req_tuser,   // first_byte
   input  dfm_queue_status_type q_status,
   output logic                 q_push,
   output dfm_item_type         q_item
);

   assign req_tready = !q_status.full;
   assign q_push     = req_tvalid && req_tready;

   always_comb begin
      q_item.data = req_tdata;
      priority if (!req_tuser) begin
         q_item.cls = CLS_DATA;
      end else if (req_tdata == START_BYTE) begin
         q_item.cls = CLS_START;
      end else begin
         q_item.cls = CLS_BAD_START;
      end
   end

   // never push into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_status.full |-> !q_push)
      else $error("dfm_front: push into a full queue");

endmodule
`default_nettype wire

FILE: rtl/dfm_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dfm_queue
// Small register FIFO that decouples the byte classifier from the parser.
// ---------------------------------------------------------------------------
module dfm_queue
   import dfm_pkg::*;
#(
   parameter int DEPTH = DFM_QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  dfm_item_type         push_item,
   input  logic                 pop,
   output dfm_item_type         pop_item,
   output dfm_queue_status_type status
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   dfm_item_type     entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign pop_item     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/dfm_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// dfm_back
// Frame parser: phase sequencer, CRC-16/ARC, size and end checks, and the
// result register toward the output channel.
// ---------------------------------------------------------------------------
module dfm_back
   import dfm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic [15:0]          frame_capacity,
   input  dfm_queue_status_type q_status,
   input  dfm_item_type         q_item,
   output logic                 q_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output dfm_result_type       rsp_result
);

   localparam logic [3:0] PH_IDLE    = 4'd0;
   localparam logic [3:0] PH_TYPE    = 4'd1;
   localparam logic [3:0] PH_REG_HI  = 4'd2;
   localparam logic [3:0] PH_REG_LO  = 4'd3;
   localparam logic [3:0] PH_LEN_HI  = 4'd4;
   localparam logic [3:0] PH_LEN_LO  = 4'd5;
   localparam logic [3:0] PH_CONTENT = 4'd6;
   localparam logic [3:0] PH_CRC_HI  = 4'd7;
   localparam logic [3:0] PH_CRC_LO  = 4'd8;
   localparam logic [3:0] PH_END     = 4'd9;

   logic [3:0]     phase_ff, phase_in;
   logic [15:0]    index_ff, index_in;
   logic [7:0]     type_ff, type_in;
   logic [15:0]    register_ff, register_in;
   logic [15:0]    length_ff, length_in;
   logic [15:0]    crc_ff, crc_in;
   logic [15:0]    rx_crc_ff, rx_crc_in;
   logic           valid_ff, valid_in;
   dfm_result_type result_ff;

   logic           emit;
   logic           emit_kind;
   logic [7:0]     emit_byte;
   logic [2:0]     emit_status;
   logic [7:0]     b;

   assign b     = q_item.data;
   assign q_pop = !q_status.empty && (!valid_ff || rsp_ready);

   always_comb begin
      phase_in    = phase_ff;
      index_in    = index_ff;
      type_in     = type_ff;
      register_in = register_ff;
      length_in   = length_ff;
      crc_in      = crc_ff;
      rx_crc_in   = rx_crc_ff;
      emit        = 1'b0;
      emit_kind   = KIND_FRAME_END;
      emit_byte   = 8'h00;
      emit_status = ST_OK;
      if (q_pop) begin
         unique case (q_item.cls)
            CLS_START, CLS_BAD_START: begin
               // new transaction: drop any partial frame
               type_in     = 8'h00;
               register_in = 16'h0000;
               length_in   = 16'h0000;
               crc_in      = 16'h0000;
               rx_crc_in   = 16'h0000;
               index_in    = 16'h0000;
               if (q_item.cls == CLS_START) begin
                  phase_in = PH_TYPE;
               end else begin
                  phase_in    = PH_IDLE;
                  emit        = 1'b1;
                  emit_status = ST_BAD_START;
               end
            end
            default: begin
               unique case (phase_ff)
                  PH_TYPE: begin
                     type_in  = b;
                     crc_in   = crc16_arc_byte(crc_ff, b);
                     phase_in = PH_REG_HI;
                  end
                  PH_REG_HI: begin
                     register_in = {b, 8'h00};
                     crc_in      = crc16_arc_byte(crc_ff, b);
                     phase_in    = PH_REG_LO;
                  end
                  PH_REG_LO: begin
                     register_in = {register_ff[15:8], b};
                     crc_in      = crc16_arc_byte(crc_ff, b);
                     phase_in    = PH_LEN_HI;
                  end
                  PH_LEN_HI: begin
                     length_in = {b, 8'h00};
                     crc_in    = crc16_arc_byte(crc_ff, b);
                     phase_in  = PH_LEN_LO;
                  end
                  PH_LEN_LO: begin
                     length_in = {length_ff[15:8], b};
                     crc_in    = crc16_arc_byte(crc_ff, b);
                     index_in  = 16'h0000;
                     if (({1'b0, length_in} + {1'b0, FRAME_OVERHEAD}) >
                         {1'b0, frame_capacity}) begin
                        phase_in    = PH_IDLE;
                        emit        = 1'b1;
                        emit_status = ST_TOO_LONG;
                     end else if (length_in == 16'h0000) begin
                        phase_in = PH_CRC_HI;
                     end else begin
                        phase_in = PH_CONTENT;
                     end
                  end
                  PH_CONTENT: begin
                     crc_in    = crc16_arc_byte(crc_ff, b);
                     index_in  = index_ff + 16'd1;
                     emit      = 1'b1;
                     emit_kind = KIND_CONTENT;
                     emit_byte = b;
                     if (index_in >= length_ff) begin
                        phase_in = PH_CRC_HI;
                     end
                  end
                  PH_CRC_HI: begin
                     rx_crc_in = {b, 8'h00};
                     phase_in  = PH_CRC_LO;
                  end
                  PH_CRC_LO: begin
                     rx_crc_in = {rx_crc_ff[15:8], b};
                     phase_in  = PH_END;
                  end
                  PH_END: begin
                     phase_in = PH_IDLE;
                     emit     = 1'b1;
                     priority if (b != END_BYTE) begin
                        emit_status = ST_BAD_END;
                     end else if (crc_ff != rx_crc_ff) begin
                        emit_status = ST_CRC_ERR;
                     end else begin
                        emit_status = ST_OK;
                     end
                  end
                  default: begin
                     // idle: ignore bytes until the next first byte
                     phase_in = PH_IDLE;
                  end
               endcase
            end
         endcase
      end

      priority if (q_pop && emit) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff    <= index_in;
      type_ff     <= type_in;
      register_ff <= register_in;
      length_ff   <= length_in;
      crc_ff      <= crc_in;
      rx_crc_ff   <= rx_crc_in;
      if (q_pop && emit) begin
         result_ff.kind            <= emit_kind;
         result_ff.content         <= emit_byte;
         result_ff.frame_type      <= type_in;
         result_ff.register_number <= register_in;
         result_ff.content_length  <= length_in;
         result_ff.status          <= emit_status;
      end
   end

   assign rsp_valid  = valid_ff;
   assign rsp_result = result_ff;

   // a content result always carries ok status
   a_content_ok: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (result_ff.kind == KIND_CONTENT) |-> (result_ff.status == ST_OK))
      else $error("dfm_back: content result with nonzero status");

   // a bad start result carries cleared header fields
   a_bad_start_clear: assert property (@(posedge clock) disable iff (reset)
      valid_ff && (result_ff.status == ST_BAD_START) |->
         (result_ff.frame_type == 8'h00) && (result_ff.register_number == 16'h0000) &&
         (result_ff.content_length == 16'h0000))
      else $error("dfm_back: bad start result with stale header");

   // never pop while the result register is stalled
   a_no_pop_stalled: assert property (@(posedge clock) disable iff (reset)
      valid_ff && !rsp_ready |-> !q_pop)
      else $error("dfm_back: queue popped while output stalled");

   // a start byte always opens the header phase
   a_start_phase: assert property (@(posedge clock) disable iff (reset)
      q_pop && (q_item.cls == CLS_START) |=> (phase_ff == PH_TYPE))
      else $error("dfm_back: start byte did not open a frame");

endmodule
`default_nettype wire

FILE: rtl/frame_deframer_crc16.sv
`default_nettype none
// ---------------------------------------------------------------------------
// frame_deframer_crc16
// Start/end byte deframer with CRC-16/ARC check.
// ---------------------------------------------------------------------------
// Takes one received byte per cycle on req_ while the classifier queue is not
// full (req_tuser flags the first byte of a transaction) and parses 0x55, type,
// register (BE), length (BE), content, CRC-16/ARC (BE) and 0xAA. Each content
// byte of a frame within capacity comes out as a content result, and each frame
// not dropped by a new first byte closes with one frame-end result carrying
// header and status. Throughput is one byte per cycle while rsp_ is not
// stalled, set by the phase step and byte-wide CRC update in the parser. An
// accepted byte is written into the classifier queue and the parser registers
// its result, if any, from the queue head. The QUEUE_DEPTH-byte queue keeps
// input flowing for up to that many beats while rsp_ stalls. frame_capacity
// resets to 256; write it through csr_ only while idle; this is not enforced.
// ---------------------------------------------------------------------------
module frame_deframer_crc16
   import dfm_pkg::*;
#(
   parameter int QUEUE_DEPTH = DFM_QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // data_byte[7:0]
   input  logic        req_tuser,   // first_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // content_byte[7:0], frame_type[15:8], register_number[31:16],
   // content_length[47:32], status[50:48], zero fill[55:51]
   output logic [55:0] rsp_tdata,
   output logic        rsp_tuser,   // result_kind
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data     // frame_capacity[15:0]
);

   logic [15:0]          capacity_ff;
   logic                 q_push;
   logic                 q_pop;
   dfm_item_type         push_item;
   dfm_item_type         pop_item;
   dfm_queue_status_type q_status;
   dfm_result_type       result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
      end else if (csr_valid && csr_ready) begin
         capacity_ff <= csr_data;
      end
   end

   dfm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   dfm_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .pop       (q_pop),
      .pop_item  (pop_item),
      .status    (q_status)
   );

   dfm_back u_back (
      .clock          (clock),
      .reset          (reset),
      .frame_capacity (capacity_ff),
      .q_status       (q_status),
      .q_item         (pop_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_tvalid),
      .rsp_ready      (rsp_tready),
      .rsp_result     (result)
   );

   assign rsp_tuser = result.kind;
   assign rsp_tdata = {5'b00000, result.status, result.content_length,
                       result.register_number, result.frame_type, result.content};

endmodule
`default_nettype wire
